>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the linked list engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pll_pkg.sv
// ---------------------------------------------------------------------------
// pll_pkg
// Types, widths and codes shared by the positional linked list engine.
// ---------------------------------------------------------------------------
package pll_pkg;

    // Pool size and derived widths.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the request and result transactions.
    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 5;
    localparam int ST_W    = 2;

    // Width used to compare positions against the element count.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_POS  = 3'd3,
        OP_READ_ALL = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INS_EMPTY,
        S_INS_HEAD,
        S_INS_HEAD2,
        S_INS_TAIL,
        S_INS_TAIL2,
        S_WALK,
        S_WALK_RUN,
        S_MID_RD,
        S_MID_W1,
        S_MID_W2,
        S_DEL_RD,
        S_DEL_W,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_RESP
    } state_t;

    // Link update performed by the datapath.
    typedef enum logic [3:0] {
        LK_NONE,
        LK_EMPTY,
        LK_HEAD1,
        LK_HEAD2,
        LK_TAIL1,
        LK_TAIL2,
        LK_MID1,
        LK_MID2,
        LK_DEL
    } link_t;

    // Read address source for the slot memories.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CUR,
        RD_CHAIN
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    alloc;
        logic    walk_init;
        logic    walk_adv;
        rd_sel_t rd_sel;
        link_t   link;
        logic    emit_elem;
        logic    emit_status;
        status_t status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic ins_ok;
        logic del_ok;
        logic ins_head;
        logic ins_tail;
        logic walk_done;
        logic walk_last;
        logic rd_last;
        logic out_free;
    } stat_t;

endpackage

>>> sv/pll_ifs.sv
// ---------------------------------------------------------------------------
// pll_ifs
// Valid/ready channels for request and result transactions.
// ---------------------------------------------------------------------------
interface pll_req_if;
    logic                                valid;
    logic                                ready;
    logic [pll_pkg::OP_W-1:0]            operation;
    logic signed [pll_pkg::VAL_W-1:0]    value;
    logic [pll_pkg::POS_W-1:0]           position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface pll_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [pll_pkg::VAL_W-1:0]    element_value;
    logic [pll_pkg::POS_W-1:0]           element_position;
    logic [pll_pkg::COUNT_W-1:0]         element_count;
    logic [pll_pkg::ST_W-1:0]            status;
    logic                                last;

    modport source (output valid, output element_value, output element_position,
                    output element_count, output status, output last, input ready);
    modport sink   (input valid, input element_value, input element_position,
                    input element_count, input status, input last, output ready);
endinterface

>>> sv/positional_linked_list_engine.sv
// Head and tail inserts, rejected requests: decode, any link writes, registered result.
// Positional insert and delete: the walk follows one next link
// per cycle through the next-link memory's registered read port.
// Read all: a memory read, then an output load, for each element; one request at a time.
// Reset is asynchronous and leaves an empty list at once; the slot memories are not
// cleared, since a slot is only read after it has been linked in.
// ---------------------------------------------------------------------------
// positional_linked_list_engine
// Bounded doubly linked list of signed values in a slot pool, with insert,
// delete and in-order read-out requests on valid/ready channels.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_linked_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    pll_req_if.sink    req,
    pll_rsp_if.source  rsp
);

    pll_pkg::cmd_t  cmd;
    pll_pkg::stat_t stat;

    // Sequencer.
    pll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and output register.
    pll_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .stat                 (stat),
        .req_operation        (req.operation),
        .req_value            (req.value),
        .req_position         (req.position),
        .rsp_ready            (rsp.ready),
        .rsp_valid            (rsp.valid),
        .rsp_element_value    (rsp.element_value),
        .rsp_element_position (rsp.element_position),
        .rsp_element_count    (rsp.element_count),
        .rsp_status           (rsp.status),
        .rsp_last             (rsp.last)
    );

    // A request is worked on alone: no second transaction right after one is taken.
    `PLL_ASSERT_NEXT(a_one_request, clk, rst_n, req.valid && req.ready, !req.ready, "request accepted while busy")

    // A failed or single result always closes its request.
    `PLL_ASSERT_NOW(a_status_last, clk, rst_n, rsp.valid && rsp.status != pll_pkg::ST_DONE, rsp.last, "error status without last")

    // Read-out elements carry done status and a position within the count.
    `PLL_ASSERT_NOW(a_elem_pos, clk, rst_n, rsp.valid && rsp.element_position != '0, (rsp.element_position <= rsp.element_count) && (rsp.status == pll_pkg::ST_DONE), "element position outside list")

endmodule

>>> sv/pll_ram.sv
// ---------------------------------------------------------------------------
// pll_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module pll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pll_ctrl.sv
// ---------------------------------------------------------------------------
// pll_ctrl
// Sequencer for list requests: decodes the request, walks the links,
// relinks slots and hands result transactions to the datapath.
// ---------------------------------------------------------------------------
module pll_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  pll_pkg::stat_t  stat,
    output pll_pkg::cmd_t   cmd
);

    pll_pkg::state_t  state_reg, state_next;
    pll_pkg::status_t st_reg, st_next;

    // State and pending status registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pll_pkg::S_IDLE;
            st_reg    <= pll_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        st_next         = st_reg;
        req_ready       = 1'b0;
        cmd.load_req    = 1'b0;
        cmd.alloc       = 1'b0;
        cmd.walk_init   = 1'b0;
        cmd.walk_adv    = 1'b0;
        cmd.rd_sel      = pll_pkg::RD_NONE;
        cmd.link        = pll_pkg::LK_NONE;
        cmd.emit_elem   = 1'b0;
        cmd.emit_status = 1'b0;
        cmd.status      = st_reg;

        case (state_reg)
            pll_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = pll_pkg::S_DECODE;
                end
            end

            pll_pkg::S_DECODE:
            begin
                st_next    = pll_pkg::ST_DONE;
                state_next = pll_pkg::S_RESP;
                case (stat.op)
                    pll_pkg::OP_INS_HEAD, pll_pkg::OP_INS_TAIL, pll_pkg::OP_INS_POS:
                    begin
                        if (stat.full)
                        begin
                            st_next = pll_pkg::ST_FULL;
                        end
                        else if (stat.op == pll_pkg::OP_INS_POS && !stat.ins_ok)
                        begin
                            st_next = pll_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.alloc = 1'b1;
                            if (stat.empty)
                            begin
                                state_next = pll_pkg::S_INS_EMPTY;
                            end
                            else if (stat.ins_head)
                            begin
                                state_next = pll_pkg::S_INS_HEAD;
                            end
                            else if (stat.ins_tail)
                            begin
                                state_next = pll_pkg::S_INS_TAIL;
                            end
                            else
                            begin
                                cmd.walk_init = 1'b1;
                                state_next    = pll_pkg::S_WALK;
                            end
                        end
                    end
                    pll_pkg::OP_DEL_POS:
                    begin
                        if (!stat.del_ok)
                        begin
                            st_next = pll_pkg::ST_RANGE;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = pll_pkg::S_WALK;
                        end
                    end
                    pll_pkg::OP_READ_ALL:
                    begin
                        if (stat.empty)
                        begin
                            st_next = pll_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = pll_pkg::S_RD_ISSUE;
                        end
                    end
                    default:
                    begin
                        st_next = pll_pkg::ST_DONE;
                    end
                endcase
            end

            pll_pkg::S_INS_EMPTY:
            begin
                cmd.link   = pll_pkg::LK_EMPTY;
                state_next = pll_pkg::S_RESP;
            end

            pll_pkg::S_INS_HEAD:
            begin
                cmd.link   = pll_pkg::LK_HEAD1;
                state_next = pll_pkg::S_INS_HEAD2;
            end

            pll_pkg::S_INS_HEAD2:
            begin
                cmd.link   = pll_pkg::LK_HEAD2;
                state_next = pll_pkg::S_RESP;
            end

            pll_pkg::S_INS_TAIL:
            begin
                cmd.link   = pll_pkg::LK_TAIL1;
                state_next = pll_pkg::S_INS_TAIL2;
            end

            pll_pkg::S_INS_TAIL2:
            begin
                cmd.link   = pll_pkg::LK_TAIL2;
                state_next = pll_pkg::S_RESP;
            end

            // Start of the walk: either already there or read the first link.
            pll_pkg::S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = (stat.op == pll_pkg::OP_DEL_POS) ? pll_pkg::S_DEL_RD
                                                                  : pll_pkg::S_MID_RD;
                end
                else
                begin
                    cmd.rd_sel = pll_pkg::RD_CUR;
                    state_next = pll_pkg::S_WALK_RUN;
                end
            end

            // One link per cycle, feeding the read data back as the next address.
            pll_pkg::S_WALK_RUN:
            begin
                cmd.walk_adv = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = (stat.op == pll_pkg::OP_DEL_POS) ? pll_pkg::S_DEL_RD
                                                                  : pll_pkg::S_MID_RD;
                end
                else
                begin
                    cmd.rd_sel = pll_pkg::RD_CHAIN;
                end
            end

            pll_pkg::S_MID_RD:
            begin
                cmd.rd_sel = pll_pkg::RD_CUR;
                state_next = pll_pkg::S_MID_W1;
            end

            pll_pkg::S_MID_W1:
            begin
                cmd.link   = pll_pkg::LK_MID1;
                state_next = pll_pkg::S_MID_W2;
            end

            pll_pkg::S_MID_W2:
            begin
                cmd.link   = pll_pkg::LK_MID2;
                state_next = pll_pkg::S_RESP;
            end

            pll_pkg::S_DEL_RD:
            begin
                cmd.rd_sel = pll_pkg::RD_CUR;
                state_next = pll_pkg::S_DEL_W;
            end

            pll_pkg::S_DEL_W:
            begin
                cmd.link   = pll_pkg::LK_DEL;
                state_next = pll_pkg::S_RESP;
            end

            pll_pkg::S_RD_ISSUE:
            begin
                cmd.rd_sel = pll_pkg::RD_CUR;
                state_next = pll_pkg::S_RD_EMIT;
            end

            // Hand one element to the output register once it is free.
            pll_pkg::S_RD_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_elem = 1'b1;
                    state_next    = stat.rd_last ? pll_pkg::S_IDLE : pll_pkg::S_RD_ISSUE;
                end
            end

            pll_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = pll_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pll_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/pll_datapath.sv
// ---------------------------------------------------------------------------
// pll_datapath
// Slot memories, list head/tail/count registers, free slot bitmap,
// walk pointer and the output register for result transactions.
// ---------------------------------------------------------------------------
module pll_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pll_pkg::cmd_t                       cmd,
    output pll_pkg::stat_t                      stat,
    input  logic [pll_pkg::OP_W-1:0]            req_operation,
    input  logic signed [pll_pkg::VAL_W-1:0]    req_value,
    input  logic [pll_pkg::POS_W-1:0]           req_position,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic signed [pll_pkg::VAL_W-1:0]    rsp_element_value,
    output logic [pll_pkg::POS_W-1:0]           rsp_element_position,
    output logic [pll_pkg::COUNT_W-1:0]         rsp_element_count,
    output logic [pll_pkg::ST_W-1:0]            rsp_status,
    output logic                                rsp_last
);

    // List control registers.
    logic [pll_pkg::IDX_W-1:0]    head_reg, head_next;
    logic [pll_pkg::IDX_W-1:0]    tail_reg, tail_next;
    logic [pll_pkg::CAPACITY-1:0] free_reg, free_next;
    logic [pll_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         out_valid_reg, out_valid_next;

    // Request and walk registers.
    pll_pkg::op_t                     op_reg;
    logic signed [pll_pkg::VAL_W-1:0] val_reg;
    logic [pll_pkg::POS_W-1:0]        pos_reg;
    logic [pll_pkg::IDX_W-1:0]        slot_reg, slot_next;
    logic [pll_pkg::IDX_W-1:0]        cur_reg, cur_next;
    logic [pll_pkg::IDX_W-1:0]        aux_reg, aux_next;
    logic [pll_pkg::CNT_W-1:0]        steps_reg, steps_next;
    logic [pll_pkg::CNT_W-1:0]        idx_reg, idx_next;

    // Output payload registers.
    logic signed [pll_pkg::VAL_W-1:0] out_value_reg;
    logic [pll_pkg::POS_W-1:0]        out_pos_reg;
    logic [pll_pkg::COUNT_W-1:0]      out_count_reg;
    logic [pll_pkg::ST_W-1:0]         out_status_reg;
    logic                             out_last_reg;

    // Memory ports.
    logic                         next_we, prev_we, rd_en;
    logic [pll_pkg::IDX_W-1:0]    next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [pll_pkg::IDX_W-1:0]    rd_addr;
    logic [pll_pkg::IDX_W-1:0]    next_rdata, prev_rdata;
    logic [pll_pkg::VAL_W-1:0]    value_rdata;

    // Derived values.
    logic [pll_pkg::IDX_W-1:0]    alloc_slot;
    logic [pll_pkg::CMP_W-1:0]    pos_x, cnt_x, walk_len;
    logic [pll_pkg::CNT_W:0]      idx_inc;
    logic                         out_free;

    // Lowest numbered free slot.
    always_comb
    begin
        alloc_slot = '0;
        for (int i = pll_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                alloc_slot = pll_pkg::IDX_W'(i);
            end
        end
    end

    // Range checks and walk length.
    assign pos_x    = pll_pkg::CMP_W'(pos_reg);
    assign cnt_x    = pll_pkg::CMP_W'(count_reg);
    assign walk_len = (op_reg == pll_pkg::OP_DEL_POS) ? (pos_x - pll_pkg::CMP_W'(1))
                                                      : (pos_x - pll_pkg::CMP_W'(2));
    assign idx_inc  = {1'b0, idx_reg} + (pll_pkg::CNT_W + 1)'(1);
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = cnt_x >= pll_pkg::CMP_W'(pll_pkg::CAPACITY);
        stat.empty     = count_reg == '0;
        stat.ins_ok    = (pos_x != '0) && (pos_x <= cnt_x + pll_pkg::CMP_W'(1));
        stat.del_ok    = (pos_x != '0) && (pos_x <= cnt_x);
        stat.ins_head  = (op_reg == pll_pkg::OP_INS_HEAD) ||
                         ((op_reg == pll_pkg::OP_INS_POS) && (pos_x == pll_pkg::CMP_W'(1)));
        stat.ins_tail  = (op_reg == pll_pkg::OP_INS_TAIL) ||
                         ((op_reg == pll_pkg::OP_INS_POS) &&
                          (pos_x == cnt_x + pll_pkg::CMP_W'(1)));
        stat.walk_done = steps_reg == '0;
        stat.walk_last = steps_reg == pll_pkg::CNT_W'(1);
        stat.rd_last   = idx_inc == {1'b0, count_reg};
        stat.out_free  = out_free;
    end

    // Read address: the walk pointer, or the link just read for chained steps.
    assign rd_en   = cmd.rd_sel != pll_pkg::RD_NONE;
    assign rd_addr = (cmd.rd_sel == pll_pkg::RD_CHAIN) ? next_rdata : cur_reg;

    // Link updates and list bookkeeping.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        aux_next   = aux_reg;
        next_we    = 1'b0;
        next_waddr = slot_reg;
        next_wdata = slot_reg;
        prev_we    = 1'b0;
        prev_waddr = slot_reg;
        prev_wdata = slot_reg;

        if (cmd.alloc)
        begin
            slot_next = alloc_slot;
            free_next = free_reg & ~(pll_pkg::CAPACITY'(1) << alloc_slot);
        end

        case (cmd.link)
            pll_pkg::LK_EMPTY:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                head_next  = slot_reg;
                tail_next  = slot_reg;
                count_next = count_reg + pll_pkg::CNT_W'(1);
            end
            pll_pkg::LK_HEAD1:
            begin
                next_we    = 1'b1;
                next_wdata = head_reg;
                prev_we    = 1'b1;
            end
            pll_pkg::LK_HEAD2:
            begin
                prev_we    = 1'b1;
                prev_waddr = head_reg;
                head_next  = slot_reg;
                count_next = count_reg + pll_pkg::CNT_W'(1);
            end
            pll_pkg::LK_TAIL1:
            begin
                prev_we    = 1'b1;
                prev_wdata = tail_reg;
                next_we    = 1'b1;
            end
            pll_pkg::LK_TAIL2:
            begin
                next_we    = 1'b1;
                next_waddr = tail_reg;
                tail_next  = slot_reg;
                count_next = count_reg + pll_pkg::CNT_W'(1);
            end
            pll_pkg::LK_MID1:
            begin
                next_we    = 1'b1;
                next_wdata = next_rdata;
                prev_we    = 1'b1;
                prev_wdata = cur_reg;
                aux_next   = next_rdata;
            end
            pll_pkg::LK_MID2:
            begin
                next_we    = 1'b1;
                next_waddr = cur_reg;
                prev_we    = 1'b1;
                prev_waddr = aux_reg;
                count_next = count_reg + pll_pkg::CNT_W'(1);
            end
            pll_pkg::LK_DEL:
            begin
                // Unlink the walked slot; next and prev read data are its links.
                if (count_reg == pll_pkg::CNT_W'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (cur_reg == head_reg)
                begin
                    head_next  = next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = next_rdata;
                end
                else if (cur_reg == tail_reg)
                begin
                    tail_next  = prev_rdata;
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = prev_rdata;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = prev_rdata;
                end
                free_next  = free_reg | (pll_pkg::CAPACITY'(1) << cur_reg);
                count_next = count_reg - pll_pkg::CNT_W'(1);
            end
            default:
            begin
                next_we = 1'b0;
            end
        endcase
    end

    // Walk pointer, step counter and read-out index.
    always_comb
    begin
        cur_next   = cur_reg;
        steps_next = steps_reg;
        idx_next   = idx_reg;
        if (cmd.walk_init)
        begin
            cur_next   = head_reg;
            steps_next = pll_pkg::CNT_W'(walk_len);
            idx_next   = '0;
        end
        else if (cmd.walk_adv)
        begin
            cur_next   = next_rdata;
            steps_next = steps_reg - pll_pkg::CNT_W'(1);
        end
        else if (cmd.emit_elem)
        begin
            cur_next = next_rdata;
            idx_next = idx_inc[pll_pkg::CNT_W-1:0];
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_elem || cmd.emit_status)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= '1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg  <= pll_pkg::op_t'(req_operation);
            val_reg <= req_value;
            pos_reg <= req_position;
        end
        slot_reg  <= slot_next;
        aux_reg   <= aux_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        idx_reg   <= idx_next;
        if (cmd.emit_elem)
        begin
            out_value_reg  <= value_rdata;
            out_pos_reg    <= pll_pkg::POS_W'(idx_inc);
            out_count_reg  <= pll_pkg::COUNT_W'(count_reg);
            out_status_reg <= pll_pkg::ST_DONE;
            out_last_reg   <= stat.rd_last;
        end
        else if (cmd.emit_status)
        begin
            out_value_reg  <= '0;
            out_pos_reg    <= '0;
            out_count_reg  <= pll_pkg::COUNT_W'(count_reg);
            out_status_reg <= cmd.status;
            out_last_reg   <= 1'b1;
        end
    end

    // Slot memories.
    pll_ram #(.WIDTH(pll_pkg::VAL_W), .DEPTH(pll_pkg::CAPACITY)) u_value_ram (
        .clk   (clk),
        .we    (cmd.alloc),
        .waddr (alloc_slot),
        .wdata (val_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (value_rdata)
    );

    pll_ram #(.WIDTH(pll_pkg::IDX_W), .DEPTH(pll_pkg::CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    pll_ram #(.WIDTH(pll_pkg::IDX_W), .DEPTH(pll_pkg::CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (prev_rdata)
    );

    // Result transaction outputs.
    assign rsp_valid            = out_valid_reg;
    assign rsp_element_value    = out_value_reg;
    assign rsp_element_position = out_pos_reg;
    assign rsp_element_count    = out_count_reg;
    assign rsp_status           = out_status_reg;
    assign rsp_last             = out_last_reg;

endmodule
